// ----- sv/dcdl_pkg.sv -----
// ---------------------------------------------------------------------------
// dcdl_pkg
// Shared types and codes for the daisy chain display link.
// ---------------------------------------------------------------------------
package dcdl_pkg;

    localparam int ROW_CHARS   = 10;
    localparam int POS_W       = 5;
    localparam int KIND_W      = 3;
    localparam int MAX_RESULTS = 3;

    // link command and payload type bytes
    localparam logic [7:0] CMD_ASSIGN  = 8'h00;
    localparam logic [7:0] CMD_FRAME   = 8'h01;
    localparam logic [7:0] TYPE_CHARS  = 8'h01;
    localparam logic [7:0] TYPE_BRIGHT = 8'h02;

    typedef enum logic [KIND_W-1:0] {
        K_TX      = 3'd0,
        K_SHOW    = 3'd1,
        K_CHAR    = 3'd2,
        K_REFRESH = 3'd3,
        K_BRIGHT  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       value;
        logic [POS_W-1:0] position;
    } res_t;

    // all results caused by one link byte
    typedef struct packed {
        res_t [MAX_RESULTS-1:0] item;
        logic [1:0]             count;
    } bundle_t;

endpackage

// ----- sv/dcdl_if.sv -----
// ---------------------------------------------------------------------------
// dcdl_if
// Valid/ready channels: link bytes in, display results out.
// ---------------------------------------------------------------------------
interface dcdl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dcdl_result_if;
    logic                              valid;
    logic                              ready;
    logic [dcdl_pkg::KIND_W-1:0]       kind;
    logic [7:0]                        value;
    logic [dcdl_pkg::POS_W-1:0]        position;
    logic                              last;

    modport source (output valid, output kind, output value, output position,
                    output last, input ready);
    modport sink   (input valid, input kind, input value, input position,
                    input last, output ready);
endinterface

// ----- sv/dcdl_step.sv -----
// ---------------------------------------------------------------------------
// dcdl_step
// Protocol state machine: one step per accepted link byte, builds the
// bundle of results that the byte causes.
// ---------------------------------------------------------------------------
module dcdl_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output dcdl_pkg::bundle_t bundle
);
    import dcdl_pkg::*;

    typedef enum logic [1:0] {
        PH_WAIT_INIT,
        PH_WAIT_ID,
        PH_READY,
        PH_RECEIVING
    } phase_t;

    phase_t           phase_reg,  phase_next;
    logic [8:0]       count_reg,  count_next;
    logic [7:0]       node_reg,   node_next;
    logic [7:0]       len_reg,    len_next;
    logic             fwd_reg,    fwd_next;
    logic [7:0]       type_reg,   type_next;
    logic [7:0]       bright_reg, bright_next;
    logic [POS_W-1:0] col_reg,    col_next;
    logic             row_reg,    row_next;

    logic [1:0] n;
    logic [8:0] count_inc;
    logic       col_wrap;

    assign col_wrap = (col_reg == POS_W'(ROW_CHARS - 1));

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        node_next   = node_reg;
        len_next    = len_reg;
        fwd_next    = fwd_reg;
        type_next   = type_reg;
        bright_next = bright_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bundle      = '0;
        n           = 2'd0;
        count_inc   = count_reg + 9'd1;

        case (phase_reg)
            PH_WAIT_INIT:
            begin
                if (rx_byte == CMD_ASSIGN)
                    phase_next = PH_WAIT_ID;
            end
            PH_WAIT_ID:
            begin
                node_next = rx_byte;
                bundle.item[0] = '{kind: K_SHOW, value: rx_byte, position: '0};
                bundle.item[1] = '{kind: K_TX, value: CMD_ASSIGN, position: '0};
                bundle.item[2] = '{kind: K_TX, value: rx_byte + 8'd1, position: '0};
                n = 2'd3;
                phase_next = PH_READY;
            end
            PH_READY:
            begin
                if (rx_byte == CMD_ASSIGN)
                    phase_next = PH_WAIT_ID;
                else if (rx_byte == CMD_FRAME)
                begin
                    phase_next = PH_RECEIVING;
                    count_next = 9'd0;
                end
            end
            PH_RECEIVING:
            begin
                if (count_reg == 9'd0)
                begin
                    fwd_next = (rx_byte != node_reg);
                    if (fwd_next)
                    begin
                        bundle.item[0] = '{kind: K_TX, value: CMD_FRAME, position: '0};
                        bundle.item[1] = '{kind: K_TX, value: rx_byte, position: '0};
                        n = 2'd2;
                    end
                end
                else if (count_reg == 9'd1)
                begin
                    len_next = rx_byte;
                    if (fwd_reg)
                    begin
                        bundle.item[0] = '{kind: K_TX, value: rx_byte, position: '0};
                        n = 2'd1;
                    end
                end
                else if (fwd_reg)
                begin
                    bundle.item[0] = '{kind: K_TX, value: rx_byte, position: '0};
                    n = 2'd1;
                end
                else if (count_reg == 9'd2)
                begin
                    // payload type byte, character index restarts
                    type_next = rx_byte;
                    col_next  = '0;
                    row_next  = 1'b0;
                end
                else
                begin
                    if (count_reg == 9'd3)
                        bright_next = rx_byte;
                    // the last payload byte of a character frame is not shown
                    if (type_reg == TYPE_CHARS && count_reg <= {1'b0, len_reg})
                    begin
                        bundle.item[0] = '{kind: K_CHAR, value: rx_byte,
                            position: row_reg ? POS_W'(ROW_CHARS) + col_reg : col_reg};
                        n = 2'd1;
                    end
                    col_next = col_wrap ? '0 : col_reg + POS_W'(1);
                    row_next = row_reg | col_wrap;
                end

                count_next = count_inc;
                if (count_inc >= {1'b0, len_next} + 9'd2)
                begin
                    if (!fwd_next && len_next != 8'd0)
                    begin
                        if (type_next == TYPE_CHARS)
                        begin
                            bundle.item[n] = '{kind: K_REFRESH, value: 8'd0, position: '0};
                            n = n + 2'd1;
                        end
                        else if (type_next == TYPE_BRIGHT && len_next >= 8'd2)
                        begin
                            bundle.item[n] = '{kind: K_BRIGHT, value: bright_next,
                                               position: '0};
                            n = n + 2'd1;
                        end
                    end
                    phase_next = PH_READY;
                end
            end
            default:
            begin
                phase_next = PH_WAIT_INIT;
            end
        endcase
        bundle.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT_INIT;
            count_reg  <= '0;
            node_reg   <= '0;
            len_reg    <= '0;
            fwd_reg    <= 1'b0;
            type_reg   <= '0;
            bright_reg <= '0;
            col_reg    <= '0;
            row_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            node_reg   <= node_next;
            len_reg    <= len_next;
            fwd_reg    <= fwd_next;
            type_reg   <= type_next;
            bright_reg <= bright_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ----- sv/dcdl_out.sv -----
// ---------------------------------------------------------------------------
// dcdl_out
// Result register: holds one byte's results and sends them one per cycle while disp is ready.
// ---------------------------------------------------------------------------
module dcdl_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dcdl_pkg::bundle_t    bundle,
    input  logic                 load,
    output logic                 can_load,
    dcdl_result_if.source        disp
);
    import dcdl_pkg::*;

    bundle_t    bundle_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       is_last;
    res_t       cur;

    assign cur     = bundle_reg.item[idx_reg];
    assign is_last = (idx_reg == bundle_reg.count - 2'd1);

    assign disp.valid    = valid_reg;
    assign disp.kind     = cur.kind;
    assign disp.value    = cur.value;
    assign disp.position = cur.position;
    assign disp.last     = is_last;

    // free now, or the final result leaves at this edge
    assign can_load = !valid_reg || (disp.ready && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && disp.ready)
        begin
            if (is_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bundle_reg <= bundle;
    end

endmodule

// ----- sv/daisy_chain_display_link.sv -----
// ---------------------------------------------------------------------------
// daisy_chain_display_link
// Link byte receiver for a daisy-chained character display node.
// ---------------------------------------------------------------------------
//   channel  dir  payload                         accepted when
//   link     in   rx_byte[7:0]                    valid && ready
//   disp     out  kind, value, position, last     valid && ready
//
// An accepted byte's results appear in the result register at the
// next edge, then leave one per cycle while disp is ready; a byte
// with no results loads nothing into the result register.
// A byte is accepted in the cycle its predecessor's last result leaves.
// Reset clears the protocol state; the node waits for ID assignment.
// A stall on disp holds the current result and blocks new link requests.
// ---------------------------------------------------------------------------
module daisy_chain_display_link (
    input  logic          clk,
    input  logic          rst_n,
    dcdl_byte_if.sink     link,
    dcdl_result_if.source disp
);
    import dcdl_pkg::*;

    bundle_t  bundle;
    logic     load;
    logic     can_load;
    logic     accept;

    assign link.ready = can_load;
    assign accept     = link.valid && link.ready;
    assign load       = accept && (bundle.count != 2'd0);

    dcdl_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (link.rx_byte),
        .bundle  (bundle)
    );

    dcdl_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .bundle   (bundle),
        .load     (load),
        .can_load (can_load),
        .disp     (disp)
    );

    a_free_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        disp.valid && disp.ready && disp.last |-> link.ready)
        else $error("link stalled while last result leaves");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> disp.valid)
        else $error("accepted request produced no result");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        disp.valid |-> disp.kind <= K_BRIGHT)
        else $error("result kind out of range");

    a_pos_only_char: assert property (@(posedge clk) disable iff (!rst_n)
        disp.valid && disp.kind != K_CHAR |-> disp.position == '0)
        else $error("position set on non-character result");

endmodule
